// ----- sv/svagm_pkg.sv -----
// ----------------------------------------------------------------------------
// svagm_pkg - shared definitions for the stereo vu auto gain meter
// Field widths, payload layout and the fixed limits of the gain control loop.
// ----------------------------------------------------------------------------
package svagm_pkg;

  localparam int unsigned LEVEL_W  = 15;
  localparam int unsigned BRIGHT_W = 12;
  localparam int unsigned GAIN_W   = 4;
  localparam int unsigned GB_W     = 16;  // gain * brightness
  localparam int unsigned PROD_W   = 31;  // level * gain * brightness
  localparam int unsigned BAR_W    = 16;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned STEP_W   = 5;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [LEVEL_W-1:0]  FULL_SCALE_LEVEL = 15'h7FFF;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET     = 12'hFFF;
  localparam logic [GAIN_W-1:0]   GAIN_MAX         = 4'd15;
  localparam logic [GAIN_W-1:0]   GAIN_MIN         = 4'd1;
  localparam logic [CNT_W-1:0]    RISE_LIMIT       = 5'd30;
  localparam logic [CNT_W-1:0]    FALL_LIMIT       = 5'd10;

  // last step index of the serial loops
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(LEVEL_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(PROD_W - 1);

endpackage

// ----- sv/stereo_vu_auto_gain_meter_core.sv -----
// ----------------------------------------------------------------------------
// stereo_vu_auto_gain_meter_core - stereo bar meter with automatic gain
// Bit-serial multiply and divide per channel, shared gain and hold counter.
// ----------------------------------------------------------------------------
// Each input transfer carries a left and a right peak level. The core returns
// one result per transfer: both bars, floor(level*gain*brightness/32767), and
// the gain after this update's adjustment. gain*brightness is latched at the
// accepting edge, then an msb-first shift-add multiply runs (one level bit per
// cycle), then a restoring divide by 32767 (one quotient bit per cycle), then
// the gain update. The core is ready again in the following cycle, so a new
// item is accepted only after the previous one's update. The update cycle
// waits while the previous result is still held in the output register. The
// next item is accepted once the update is done, even while that result still
// waits.
// Brightness is written through the cfg port and may be changed only while the
// core is idle.
module stereo_vu_auto_gain_meter_core
  import svagm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // config write: full_scale_brightness
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [BRIGHT_W-1:0]   cfg_data,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [14:0] left_level, [29:15] right_level
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [15:0] left_bar, [31:16] right_bar,
                                            // [35:32] gain_now
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_UPD
  } state_t;

  state_t                state_r, state_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [BRIGHT_W-1:0]   bright_r, bright_nxt;
  logic [GAIN_W-1:0]     gain_r, gain_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [GB_W-1:0]       gb_r, gb_nxt;
  logic [LEVEL_W-1:0]    lvl_l_r, lvl_l_nxt, lvl_r_r, lvl_r_nxt;
  logic [PROD_W-1:0]     prod_l_r, prod_l_nxt, prod_r_r, prod_r_nxt;
  logic [LEVEL_W-1:0]    rem_l_r, rem_l_nxt, rem_r_r, rem_r_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                  in_xfer;
  logic [LEVEL_W:0]      sh_l, sh_r;
  logic                  ge_l, ge_r;
  logic [BAR_W-1:0]      bar_l, bar_r, ctl;
  logic [BAR_W-1:0]      half_b, full_b;
  logic [CNT_W-1:0]      cnt_inc;
  logic                  out_free;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // restoring divide step: shift in next product bit, subtract when it fits
  assign sh_l = {rem_l_r, prod_l_r[PROD_W-1]};
  assign sh_r = {rem_r_r, prod_r_r[PROD_W-1]};
  assign ge_l = (sh_l >= {1'b0, FULL_SCALE_LEVEL});
  assign ge_r = (sh_r >= {1'b0, FULL_SCALE_LEVEL});

  // after the divide the product registers hold the quotients
  assign bar_l  = prod_l_r[BAR_W-1:0];
  assign bar_r  = prod_r_r[BAR_W-1:0];
  // bar grows with level, so the louder channel's bar is the control bar
  assign ctl    = (bar_r > bar_l) ? bar_r : bar_l;
  assign half_b = {{(BAR_W-BRIGHT_W+1){1'b0}}, bright_r[BRIGHT_W-1:1]};
  assign full_b = {{(BAR_W-BRIGHT_W){1'b0}}, bright_r};
  assign cnt_inc  = cnt_r + 1'b1;
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    bright_nxt     = bright_r;
    gain_nxt       = gain_r;
    cnt_nxt        = cnt_r;
    gb_nxt         = gb_r;
    lvl_l_nxt      = lvl_l_r;
    lvl_r_nxt      = lvl_r_r;
    prod_l_nxt     = prod_l_r;
    prod_r_nxt     = prod_r_r;
    rem_l_nxt      = rem_l_r;
    rem_r_nxt      = rem_r_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;

    if (cfg_valid) begin
      bright_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          lvl_l_nxt  = in_tdata[LEVEL_W-1:0];
          lvl_r_nxt  = in_tdata[2*LEVEL_W-1:LEVEL_W];
          gb_nxt     = GB_W'(gain_r * bright_r);
          prod_l_nxt = '0;
          prod_r_nxt = '0;
          step_nxt   = '0;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        // msb-first shift-add, one level bit per cycle
        prod_l_nxt = {prod_l_r[PROD_W-2:0], 1'b0}
                   + (lvl_l_r[LEVEL_W-1] ? PROD_W'(gb_r) : '0);
        prod_r_nxt = {prod_r_r[PROD_W-2:0], 1'b0}
                   + (lvl_r_r[LEVEL_W-1] ? PROD_W'(gb_r) : '0);
        lvl_l_nxt  = {lvl_l_r[LEVEL_W-2:0], 1'b0};
        lvl_r_nxt  = {lvl_r_r[LEVEL_W-2:0], 1'b0};
        if (step_r == MUL_LAST) begin
          step_nxt  = '0;
          rem_l_nxt = '0;
          rem_r_nxt = '0;
          state_nxt = ST_DIV;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DIV: begin
        rem_l_nxt  = ge_l ? LEVEL_W'(sh_l - {1'b0, FULL_SCALE_LEVEL}) : sh_l[LEVEL_W-1:0];
        rem_r_nxt  = ge_r ? LEVEL_W'(sh_r - {1'b0, FULL_SCALE_LEVEL}) : sh_r[LEVEL_W-1:0];
        prod_l_nxt = {prod_l_r[PROD_W-2:0], ge_l};
        prod_r_nxt = {prod_r_r[PROD_W-2:0], ge_r};
        if (step_r == DIV_LAST) begin
          state_nxt = ST_UPD;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_UPD: begin
        if (out_free) begin
          priority if (ctl < half_b) begin
            if (cnt_inc > RISE_LIMIT) begin
              cnt_nxt = '0;
              if (gain_r < GAIN_MAX) gain_nxt = gain_r + 1'b1;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end else if (ctl > full_b) begin
            if (cnt_inc > FALL_LIMIT) begin
              cnt_nxt = '0;
              if (gain_r > GAIN_MIN) gain_nxt = gain_r - 1'b1;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end else begin
            cnt_nxt = '0;
          end
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {(OUT_DATA_W-2*BAR_W-GAIN_W)'(0), gain_nxt, bar_r, bar_l};
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      bright_r     <= BRIGHT_RESET;
      gain_r       <= GAIN_MIN;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      bright_r     <= bright_nxt;
      gain_r       <= gain_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gb_r        <= gb_nxt;
    lvl_l_r     <= lvl_l_nxt;
    lvl_r_r     <= lvl_r_nxt;
    prod_l_r    <= prod_l_nxt;
    prod_r_r    <= prod_r_nxt;
    rem_l_r     <= rem_l_nxt;
    rem_r_r     <= rem_r_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // gain never leaves its range
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r >= GAIN_MIN && gain_r <= GAIN_MAX)
    else $error("gain out of range");

  // hold counter never passes the rise limit
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RISE_LIMIT)
    else $error("hold counter out of range");

  // gain only moves in the update cycle and then the counter restarts
  a_gain_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_UPD) |=> $stable(gain_r))
    else $error("gain changed outside update");

  a_gain_clears_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && gain_nxt != gain_r) |=> cnt_r == '0)
    else $error("gain step without counter clear");

  // divide remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> (rem_l_r != FULL_SCALE_LEVEL && rem_r_r != FULL_SCALE_LEVEL))
    else $error("divide remainder overflow");

endmodule

// ----- test/stereo_vu_auto_gain_meter_core_tb.sv -----
// ----------------------------------------------------------------------------
// stereo_vu_auto_gain_meter_core_tb - self-checking bench for the vu meter core
// A short table of directed updates and brightness writes is followed by
// bursts of quiet, loud and mixed stereo levels under four idling modes.
// Bars and gain are checked against typed rows or a bench model with hold.
// ----------------------------------------------------------------------------
module stereo_vu_auto_gain_meter_core_tb;
  import svagm_pkg::*;

  localparam int unsigned LEVEL_FULL   = 32767;
  localparam int unsigned GAIN_TOP     = 15;
  localparam int unsigned GAIN_FLOOR   = 1;
  localparam int unsigned RISE_AFTER   = 30;
  localparam int unsigned FALL_AFTER   = 10;
  localparam int unsigned PHASE_ITEMS  = 185;
  localparam int unsigned SETTLE_CYC   = 64;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned NPLAN        = 20;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum int {BAND_LOW, BAND_MID, BAND_HIGH} band_t;
  typedef enum int {BURST_QUIET, BURST_LOUD, BURST_MIXED} burst_t;

  typedef struct packed {
    logic [BAR_W-1:0]  left_bar;
    logic [BAR_W-1:0]  right_bar;
    logic [GAIN_W-1:0] gain_now;
  } meter_result_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [LEVEL_W-1:0]  left;
    logic [LEVEL_W-1:0]  right;
    logic [BRIGHT_W-1:0] bright;
    logic                typed;
    meter_result_t       res;
  } plan_row_t;

  // typed results only where they follow directly from reset state or extremes
  localparam plan_row_t PLAN [NPLAN] = '{
    '{ROW_ITEM, 15'd0,      15'd0,      12'd0,    1'b1, '{16'd0,    16'd0,    4'd1}},
    '{ROW_ITEM, 15'd32767,  15'd32767,  12'd0,    1'b1, '{16'd4095, 16'd4095, 4'd1}},
    '{ROW_ITEM, 15'd32767,  15'd0,      12'd0,    1'b1, '{16'd4095, 16'd0,    4'd1}},
    '{ROW_ITEM, 15'd0,      15'd32767,  12'd0,    1'b1, '{16'd0,    16'd4095, 4'd1}},
    '{ROW_ITEM, 15'd16384,  15'd16383,  12'd0,    1'b0, '0},
    '{ROW_ITEM, 15'd16383,  15'd16384,  12'd0,    1'b0, '0},
    '{ROW_ITEM, 15'd16367,  15'd5,      12'd0,    1'b0, '0},
    '{ROW_ITEM, 15'h5555,   15'h2AAA,   12'd0,    1'b0, '0},
    '{ROW_ITEM, 15'h2AAA,   15'h5555,   12'd0,    1'b0, '0},
    // zero brightness: everything dark, gain untouched
    '{ROW_CFG,  15'd0,      15'd0,      12'd0,    1'b0, '0},
    '{ROW_ITEM, 15'd32767,  15'd32767,  12'd0,    1'b1, '{16'd0,    16'd0,    4'd1}},
    '{ROW_ITEM, 15'd0,      15'd0,      12'd0,    1'b1, '{16'd0,    16'd0,    4'd1}},
    '{ROW_CFG,  15'd0,      15'd0,      12'd1,    1'b0, '0},
    '{ROW_ITEM, 15'd32767,  15'd32767,  12'd0,    1'b1, '{16'd1,    16'd1,    4'd1}},
    '{ROW_ITEM, 15'd32766,  15'd0,      12'd0,    1'b1, '{16'd0,    16'd0,    4'd1}},
    '{ROW_ITEM, 15'd0,      15'd0,      12'd0,    1'b1, '{16'd0,    16'd0,    4'd1}},
    '{ROW_CFG,  15'd0,      15'd0,      12'hFFF,  1'b0, '0},
    '{ROW_ITEM, 15'd32767,  15'd1,      12'd0,    1'b1, '{16'd4095, 16'd0,    4'd1}},
    '{ROW_ITEM, 15'd1,      15'd1,      12'd0,    1'b0, '0},
    '{ROW_ITEM, 15'd16380,  15'd16370,  12'd0,    1'b0, '0}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [BRIGHT_W-1:0]   cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [14:0] left_level, [29:15] right_level
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [15:0] left_bar, [31:16] right_bar,
                                            // [35:32] gain_now

  // bench-side meter state
  logic [GAIN_W-1:0]   meter_gain  = 4'd1;
  logic [CNT_W-1:0]    hold_count  = '0;
  logic [BRIGHT_W-1:0] bright      = 12'hFFF;
  band_t               last_band   = BAND_MID;

  meter_result_t pending_bars[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned updates_sent  = 0;
  int unsigned results_seen  = 0;
  int unsigned bright_writes = 0;
  int unsigned gain_rises    = 0;
  int unsigned gain_falls    = 0;
  int unsigned top_rises     = 0;
  int unsigned band_carries  = 0;
  int unsigned peak_gain     = 1;

  stereo_vu_auto_gain_meter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_bars.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic int unsigned scaled_bar(input logic [LEVEL_W-1:0] level);
    longint unsigned prod;
    prod = longint'(level) * longint'(meter_gain) * longint'(bright);
    return int'(prod / LEVEL_FULL);
  endfunction

  // one meter update: bars at the old gain, then the hold/gain adjustment
  function automatic meter_result_t advance_meter(input logic [LEVEL_W-1:0] l, r);
    meter_result_t res;
    logic [LEVEL_W-1:0] louder;
    int unsigned ctl;
    band_t band;
    louder        = (r > l) ? r : l;
    res.left_bar  = BAR_W'(scaled_bar(l));
    res.right_bar = BAR_W'(scaled_bar(r));
    ctl           = scaled_bar(louder);
    if (ctl < (int'(bright) >> 1))
      band = BAND_LOW;
    else if (ctl > int'(bright))
      band = BAND_HIGH;
    else
      band = BAND_MID;
    if (band == BAND_MID) begin
      hold_count = '0;
    end else begin
      // shared counter keeps its count across a direct band switch
      if (hold_count != 0 && band != last_band)
        band_carries++;
      hold_count = hold_count + 5'd1;
      if (band == BAND_LOW && hold_count > RISE_AFTER) begin
        hold_count = '0;
        if (meter_gain < GAIN_TOP) begin
          meter_gain = meter_gain + 4'd1;
          gain_rises++;
        end else begin
          top_rises++;
        end
      end else if (band == BAND_HIGH && hold_count > FALL_AFTER) begin
        hold_count = '0;
        if (meter_gain > GAIN_FLOOR) begin
          meter_gain = meter_gain - 4'd1;
          gain_falls++;
        end
      end
      last_band = band;
    end
    if (meter_gain > peak_gain)
      peak_gain = meter_gain;
    res.gain_now = meter_gain;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch at result %0d: %s got %0d expected %0d",
             results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    meter_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bars.size() == 0) begin
        flag_mismatch("unexpected transfer, left_bar", int'(out_tdata[15:0]), -1);
      end else begin
        want = pending_bars.pop_front();
        if (out_tdata[15:0] !== want.left_bar)
          flag_mismatch("left_bar", int'(out_tdata[15:0]), int'(want.left_bar));
        if (out_tdata[31:16] !== want.right_bar)
          flag_mismatch("right_bar", int'(out_tdata[31:16]), int'(want.right_bar));
        if (out_tdata[35:32] !== want.gain_now)
          flag_mismatch("gain_now", int'(out_tdata[35:32]), int'(want.gain_now));
      end
      results_seen++;
    end
  end

  task automatic send_levels(input logic [LEVEL_W-1:0] l, r, input logic typed,
                             input meter_result_t typed_res);
    meter_result_t res;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, r, l};
    do @(posedge clk); while (!in_tready);
    res = advance_meter(l, r);
    pending_bars.push_back(typed ? typed_res : res);
    updates_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_bars.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_brightness(input logic [BRIGHT_W-1:0] value);
    hold_until_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    bright = value;
    bright_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [BRIGHT_W-1:0] phase_bright [4];
    logic [LEVEL_W-1:0]  lvl_a, lvl_b;
    burst_t              burst;
    int unsigned         roll, burst_len, quiet_pct, ceiling, phase_sent;

    phase_bright[0] = 12'hFFF;
    phase_bright[1] = BRIGHT_W'($urandom_range(1, 4094));
    phase_bright[2] = 12'd2500;
    phase_bright[3] = 12'hFFF;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NPLAN; i++) begin
      if (PLAN[i].kind == ROW_CFG)
        write_brightness(PLAN[i].bright);
      else
        send_levels(PLAN[i].left, PLAN[i].right, PLAN[i].typed, PLAN[i].res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      unique case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 48; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      write_brightness(phase_bright[ph]);
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS) begin
        // lean on quiet runs until the gain has hit its ceiling once
        quiet_pct = (top_rises == 0) ? 80 : 45;
        roll = $urandom_range(0, 99);
        if (roll < quiet_pct) begin
          burst = BURST_QUIET;
          burst_len = $urandom_range(24, 40);
        end else if (roll < quiet_pct + 12) begin
          burst = BURST_LOUD;
          burst_len = $urandom_range(6, 14);
        end else begin
          burst = BURST_MIXED;
          burst_len = $urandom_range(1, 6);
        end
        for (int k = 0; k < burst_len && phase_sent < PHASE_ITEMS; k++) begin
          unique case (burst)
            BURST_QUIET: begin
              ceiling = 16000 / meter_gain;
              lvl_a = LEVEL_W'($urandom_range(0, ceiling));
              lvl_b = LEVEL_W'($urandom_range(0, ceiling));
            end
            BURST_LOUD: begin
              ceiling = 34000 / meter_gain;
              if (ceiling > LEVEL_FULL)
                ceiling = LEVEL_FULL;
              lvl_a = LEVEL_W'($urandom_range(ceiling, LEVEL_FULL));
              lvl_b = LEVEL_W'($urandom);
              if ($urandom_range(0, 1) == 1) begin
                lvl_a = lvl_a ^ lvl_b;
                lvl_b = lvl_a ^ lvl_b;
                lvl_a = lvl_a ^ lvl_b;
              end
            end
            default: begin
              lvl_a = LEVEL_W'($urandom);
              lvl_b = LEVEL_W'($urandom);
            end
          endcase
          send_levels(lvl_a, lvl_b, 1'b0, '0);
          phase_sent++;
          // sender backs off until the pipeline is empty
          if (ph == 1 && phase_sent == 60)
            hold_until_drained();
        end
      end
    end

    hold_until_drained();
    repeat (SETTLE_CYC) @(posedge clk);

    $display("%0d updates over %0d brightness writes, zero and unit brightness included",
             updates_sent, bright_writes);
    $display("gain rose %0d, fell %0d, held at max %0d, peak %0d, band carry-overs %0d",
             gain_rises, gain_falls, top_rises, peak_gain, band_carries);
    if (mismatches == 0 && pending_bars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- stereo_vu_auto_gain_meter_core.f -----
sv/svagm_pkg.sv
sv/stereo_vu_auto_gain_meter_core.sv
test/stereo_vu_auto_gain_meter_core_tb.sv
